/* sv/bmhpq_pkg.sv */
// Shared types for the binary max-heap priority queue core.
// No dependencies; imported by the step unit and the top level.
package bmhpq_pkg;

  // Outcome of one signed priority compare, a against b
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_t;

endpackage

/* sv/bmhpq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the heap array of the priority queue core.
module bmhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/bmhpq_step.sv */
// Shared sift step unit: parent and child slot indexes of the current hole
// and one signed priority compare. Depends on bmhpq_pkg.
module bmhpq_step #(
  parameter int AW        = 6,
  parameter int PRIO_BITS = 16
) (
  input  logic [AW-1:0]               hole_i,
  input  logic signed [PRIO_BITS-1:0] a_i,
  input  logic signed [PRIO_BITS-1:0] b_i,
  output logic [AW-1:0]               parent_o,
  output logic [AW+1:0]               left_o,
  output logic [AW+1:0]               right_o,
  output bmhpq_pkg::cmp_t             cmp_o
);
  import bmhpq_pkg::*;

  logic [AW-1:0] hole_m1;
  cmp_t          cmp;

  // parent = (hole - 1) / 2, children = 2 * hole + 1 and 2 * hole + 2
  assign hole_m1  = hole_i - AW'(1);
  assign parent_o = hole_m1 >> 1;
  assign left_o   = {1'b0, hole_i, 1'b1};
  assign right_o  = left_o + (AW+2)'(1);

  assign cmp.gt = a_i > b_i;
  assign cmp.eq = a_i == b_i;
  assign cmp_o  = cmp;

endmodule

/* sv/binary_max_heap_priority_queue_core.sv */
// Top level of the binary max-heap priority queue core: request stream in,
// status stream out. Depends on bmhpq_pkg, bmhpq_ram and bmhpq_step.
//
// One request is taken at a time; s_axis_tready is high only while the
// sequencer is idle. All heap traffic goes through one RAM with one write
// and one registered read port, and one shared compare unit. An insert
// climbs with one parent read and one compare-move per level until it
// reaches the root or a larger parent stops it. A remove moves the last
// entry to the root and descends with read left, read right, pick child
// and compare-move per level until it reaches a leaf or stops above one;
// a remove that empties the heap and a refused request skip the sift.
// The result word is held in an output register, so a finished result
// waits there while the next request is accepted. The heap needs no
// clearing after reset: only slots below the entry count are ever used,
// and the root read of an empty heap is masked to zero.
module binary_max_heap_priority_queue_core #(
  parameter int CAPACITY  = 64,
  parameter int PRIO_BITS = 16,
  parameter int TAG_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: prio_in, tag_in (from bit 0 up), zero padded to bytes
  input  logic [((PRIO_BITS+TAG_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: req_type
  input  logic [0:0] s_axis_tuser,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  // tdata: accepted, top_valid, top_prio, top_tag, count, is_full, is_empty
  // (from bit 0 up), zero padded to bytes
  output logic [((PRIO_BITS+TAG_BITS+$clog2(CAPACITY+1)+4+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready
);
  import bmhpq_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int EW    = PRIO_BITS + TAG_BITS;
  localparam int OUT_W = ((PRIO_BITS + TAG_BITS + CW + 4 + 7) / 8) * 8;
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_LAST,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DN_MOV,
    S_ROOT,
    S_OUT
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     count_q;
  logic              ok_q;
  logic              ovalid_q;
  logic [OUT_W-1:0]  odata_q;
  logic [EW-1:0]     x_q;
  logic [EW-1:0]     kid_q;
  logic [AW-1:0]     hole_q;
  logic [AW-1:0]     kid_idx_q;

  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_wdata;
  logic [EW-1:0]     ram_rdata;

  logic [AW-1:0]     parent_idx;
  logic [AW+1:0]     left_idx;
  logic [AW+1:0]     right_idx;
  logic [AW+1:0]     count_ext;
  logic              left_in;
  logic              right_in;
  logic signed [PRIO_BITS-1:0] cmp_a;
  logic signed [PRIO_BITS-1:0] cmp_b;
  logic signed [PRIO_BITS-1:0] rd_prio;
  logic signed [PRIO_BITS-1:0] x_prio;
  logic signed [PRIO_BITS-1:0] kid_prio;
  cmp_t              cmp;

  logic              in_acc;
  logic              top_valid;
  logic [EW-1:0]     top_entry;
  logic [OUT_W-1:0]  out_word;

  bmhpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bmhpq_step #(
    .AW        (AW),
    .PRIO_BITS (PRIO_BITS)
  ) u_step (
    .hole_i   (hole_q),
    .a_i      (cmp_a),
    .b_i      (cmp_b),
    .parent_o (parent_idx),
    .left_o   (left_idx),
    .right_o  (right_idx),
    .cmp_o    (cmp)
  );

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign rd_prio   = ram_rdata[TAG_BITS +: PRIO_BITS];
  assign x_prio    = x_q[TAG_BITS +: PRIO_BITS];
  assign kid_prio  = kid_q[TAG_BITS +: PRIO_BITS];
  assign count_ext = (AW+2)'(count_q);
  assign left_in   = left_idx < count_ext;
  assign right_in  = right_idx < count_ext;

  // RAM port and compare operand steering
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = hole_q;
    ram_wdata = x_q;
    ram_raddr = '0;
    cmp_a     = x_prio;
    cmp_b     = kid_prio;
    unique case (state_q)
      S_IDLE: begin
        // fetch the last entry as soon as a remove is taken
        if (in_acc && s_axis_tuser[0] && count_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(count_q - CW'(1));
        end
      end
      S_UP_RD: begin
        if (hole_q == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = parent_idx;
        end
      end
      S_UP_CMP: begin
        cmp_a     = rd_prio;
        cmp_b     = x_prio;
        ram_we    = 1'b1;
        ram_wdata = cmp.gt ? x_q : ram_rdata;
      end
      S_DN_RDL: begin
        if (!left_in) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(left_idx);
        end
      end
      S_DN_RDR: begin
        if (right_in) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(right_idx);
        end
      end
      S_DN_CMP: begin
        cmp_a = rd_prio;
        cmp_b = kid_prio;
      end
      S_DN_MOV: begin
        ram_we    = 1'b1;
        ram_wdata = (cmp.gt || cmp.eq) ? x_q : kid_q;
      end
      S_ROOT: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign top_valid = count_q != '0;
  assign top_entry = top_valid ? ram_rdata : '0;
  assign out_word  = OUT_W'({(count_q == '0), (count_q == CapCnt), count_q,
                             top_entry[TAG_BITS-1:0], top_entry[TAG_BITS +: PRIO_BITS],
                             top_valid, ok_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      ok_q      <= 1'b0;
      ovalid_q  <= 1'b0;
      odata_q   <= '0;
      x_q       <= '0;
      kid_q     <= '0;
      hole_q    <= '0;
      kid_idx_q <= '0;
    end else begin
      // the output step reloads the word itself
      if (ovalid_q && m_axis_tready && state_q != S_OUT) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            x_q    <= {s_axis_tdata[0 +: PRIO_BITS], s_axis_tdata[PRIO_BITS +: TAG_BITS]};
            hole_q <= AW'(count_q);
            if (!s_axis_tuser[0]) begin
              if (count_q != CapCnt) begin
                ok_q    <= 1'b1;
                count_q <= count_q + CW'(1);
                state_q <= S_UP_RD;
              end else begin
                ok_q    <= 1'b0;
                state_q <= S_ROOT;
              end
            end else if (count_q != '0) begin
              ok_q    <= 1'b1;
              count_q <= count_q - CW'(1);
              state_q <= S_RM_LAST;
            end else begin
              ok_q    <= 1'b0;
              state_q <= S_ROOT;
            end
          end
        end
        S_UP_RD: begin
          state_q <= (hole_q == '0) ? S_ROOT : S_UP_CMP;
        end
        S_UP_CMP: begin
          // stop below a strictly larger parent, else move the parent down
          if (cmp.gt) begin
            state_q <= S_ROOT;
          end else begin
            hole_q  <= parent_idx;
            state_q <= S_UP_RD;
          end
        end
        S_RM_LAST: begin
          x_q     <= ram_rdata;
          hole_q  <= '0;
          state_q <= (count_q == '0) ? S_ROOT : S_DN_RDL;
        end
        S_DN_RDL: begin
          state_q <= left_in ? S_DN_RDR : S_ROOT;
        end
        S_DN_RDR: begin
          kid_q     <= ram_rdata;
          kid_idx_q <= AW'(left_idx);
          state_q   <= S_DN_CMP;
        end
        S_DN_CMP: begin
          // take the right child only if strictly larger
          if (right_in && cmp.gt) begin
            kid_q     <= ram_rdata;
            kid_idx_q <= AW'(right_idx);
          end
          state_q <= S_DN_MOV;
        end
        S_DN_MOV: begin
          if (cmp.gt || cmp.eq) begin
            state_q <= S_ROOT;
          end else begin
            hole_q  <= kid_idx_q;
            state_q <= S_DN_RDL;
          end
        end
        S_ROOT: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!ovalid_q || m_axis_tready) begin
            odata_q  <= out_word;
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count above capacity");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) < count_q))
    else $error("heap write outside stored entries");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tuser[0] && count_q != CapCnt)
      |=> count_q == $past(count_q) + CW'(1))
    else $error("accepted insert did not grow the heap");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_OUT))
    else $error("result word raised outside the output step");
`endif

endmodule
